/* rtl/core/rcw_pkg.sv */
// types, constants and helper functions for the reno congestion window block
// no dependencies
package rcw_pkg;

  localparam int unsigned WINDOW_BITS   = 32;
  localparam int unsigned SEQUENCE_BITS = 32;

  localparam logic [WINDOW_BITS-1:0] WIN_MAX   = '1;
  localparam logic [1:0]             DUP_LIMIT = 2'd3;

  localparam logic [15:0] SEGMENT_SIZE_RESET = 16'd1024;
  localparam logic [31:0] INIT_THRESH_RESET  = 32'd65536;

  localparam logic REG_SEGMENT_SIZE = 1'b0;
  localparam logic REG_INIT_THRESH  = 1'b1;

  typedef enum logic [1:0] {
    PHASE_SLOW    = 2'd0,
    PHASE_AVOID   = 2'd1,
    PHASE_RECOVER = 2'd2
  } phase_e;

  typedef enum logic {
    OP_ACK     = 1'b0,
    OP_TIMEOUT = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] ack_number;
    logic [31:0] receiver_window;
  } in_word_t;

  typedef struct packed {
    logic [31:0] send_window;
    logic [31:0] congestion_window;
    logic [31:0] slow_start_threshold;
    logic [1:0]  phase;
    logic        retransmit;
  } out_word_t;

  typedef struct packed {
    phase_e                   phase;
    logic [WINDOW_BITS-1:0]   cwnd;
    logic [WINDOW_BITS-1:0]   threshold;
    logic [1:0]               dup_count;
    logic [SEQUENCE_BITS-1:0] prev_ack;
    logic                     prev_ack_valid;
    logic [WINDOW_BITS-1:0]   adv_window;
  } cw_state_t;

  function automatic logic [15:0] mss_of(input logic [15:0] seg);
    mss_of = (seg == 16'd0) ? 16'd1 : seg;
  endfunction

  function automatic cw_state_t restart_state(input logic [15:0] seg,
                                              input logic [31:0] thr);
    logic [WINDOW_BITS-1:0] th;
    cw_state_t              s;
    if (64'(thr) > 64'(WIN_MAX)) begin
      th = WIN_MAX;
    end else begin
      th = WINDOW_BITS'(thr);
    end
    if (th == '0) begin
      th = WINDOW_BITS'(1);
    end
    s.phase          = PHASE_SLOW;
    s.cwnd           = WINDOW_BITS'(mss_of(seg));
    s.threshold      = th;
    s.dup_count      = 2'd0;
    s.prev_ack       = '0;
    s.prev_ack_valid = 1'b0;
    s.adv_window     = th;
    restart_state    = s;
  endfunction

  function automatic logic [WINDOW_BITS-1:0] sat_add(input logic [WINDOW_BITS-1:0] a,
                                                     input logic [WINDOW_BITS+1:0] b);
    logic [WINDOW_BITS+2:0] sum;
    sum = (WINDOW_BITS+3)'(a) + (WINDOW_BITS+3)'(b);
    if (sum > (WINDOW_BITS+3)'(WIN_MAX)) begin
      sat_add = WIN_MAX;
    end else begin
      sat_add = WINDOW_BITS'(sum);
    end
  endfunction

endpackage

/* rtl/core/reno_congestion_window.sv */
// top level of the reno congestion window block: handshake stages, config port, state
// depends on rcw_pkg and rcw_next
//
// Each accepted word is one event, an ack or a retransmit timeout, and gives exactly
// one result word with the usable send window, congestion window, threshold, phase
// and retransmit flag. An event goes from the input register through one stage of
// compare, add and shift logic into the output register, so the block takes one word
// per cycle while the output register is free or being read; while a result waits
// downstream the input register can still take one more word. Writing either config
// register (segment size at 0x0, initial threshold at 0x4) restarts the window state
// from the new values and is meant to be done only while no event is in flight.
module reno_congestion_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rcw_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rcw_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rcw_pkg::*;

  logic [15:0] seg_q;
  logic [31:0] thr_q;
  logic        cfg_wr;
  logic [15:0] seg_d;
  logic [31:0] thr_d;

  logic      inq_valid_q;
  in_word_t  inq_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  logic      advance;

  cw_state_t state_q;
  cw_state_t state_d;
  out_word_t result;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign seg_d  = (cfg_wr && paddr[2] == REG_SEGMENT_SIZE) ? pwdata[15:0] : seg_q;
  assign thr_d  = (cfg_wr && paddr[2] == REG_INIT_THRESH)  ? pwdata       : thr_q;
  assign prdata = (paddr[2] == REG_SEGMENT_SIZE) ? {16'd0, seg_q} : thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEGMENT_SIZE_RESET;
      thr_q <= INIT_THRESH_RESET;
    end else begin
      seg_q <= seg_d;
      thr_q <= thr_d;
    end
  end

  // handshake stages
  assign advance    = inq_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !inq_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        inq_valid_q <= 1'b1;
      end else if (advance) begin
        inq_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= result;
    end
  end

  rcw_next u_next (
    .state_i  (state_q),
    .word_i   (inq_word_q),
    .mss_i    (mss_of(seg_q)),
    .state_o  (state_d),
    .result_o (result)
  );

  // window state, restarted by any config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= restart_state(SEGMENT_SIZE_RESET, INIT_THRESH_RESET);
    end else if (cfg_wr) begin
      state_q <= restart_state(seg_d, thr_d);
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/core/rcw_next.sv */
// next-state and result logic for one event of the congestion window machine
// depends on rcw_pkg
module rcw_next (
  input  rcw_pkg::cw_state_t state_i,
  input  rcw_pkg::in_word_t  word_i,
  input  logic [15:0]        mss_i,
  output rcw_pkg::cw_state_t state_o,
  output rcw_pkg::out_word_t result_o
);
  import rcw_pkg::*;

  logic [WINDOW_BITS-1:0]   mss_w;
  logic [WINDOW_BITS+1:0]   mss_x;
  logic [WINDOW_BITS+1:0]   mss3_x;
  logic [WINDOW_BITS-1:0]   half_now;
  logic [WINDOW_BITS-1:0]   thr_timeout;
  logic [SEQUENCE_BITS-1:0] ack;
  logic                     dup;
  logic [1:0]               dc_inc;
  logic [WINDOW_BITS-1:0]   cw_grow;
  logic [WINDOW_BITS-1:0]   half_grow;
  logic [WINDOW_BITS-1:0]   thr_recover;
  logic [WINDOW_BITS-1:0]   win;
  logic                     resend;
  cw_state_t                s;

  assign mss_w  = WINDOW_BITS'(mss_i);
  assign mss_x  = (WINDOW_BITS+2)'(mss_i);
  assign mss3_x = mss_x + (mss_x << 1);

  assign half_now    = state_i.cwnd >> 1;
  assign thr_timeout = (half_now > mss_w) ? half_now : mss_w;

  assign ack = SEQUENCE_BITS'(word_i.ack_number);
  assign dup = state_i.prev_ack_valid && (ack == state_i.prev_ack);

  // dup count after this ack while in slow start or avoidance
  assign dc_inc = dup ? ((state_i.dup_count < DUP_LIMIT) ? state_i.dup_count + 2'd1
                                                           : state_i.dup_count)
                      : 2'd0;
  assign cw_grow     = dup ? state_i.cwnd : sat_add(state_i.cwnd, mss_x);
  assign half_grow   = cw_grow >> 1;
  assign thr_recover = (half_grow > mss_w) ? half_grow : mss_w;

  always_comb begin
    s      = state_i;
    resend = 1'b0;
    if (word_i.opcode == OP_TIMEOUT) begin
      s.threshold = thr_timeout;
      s.cwnd      = mss_w;
      s.dup_count = 2'd0;
      s.phase     = PHASE_SLOW;
      resend      = 1'b1;
    end else begin
      s.adv_window = WINDOW_BITS'(word_i.receiver_window);
      case (state_i.phase)
        PHASE_SLOW, PHASE_AVOID: begin
          s.dup_count = dc_inc;
          s.cwnd      = cw_grow;
          if (dc_inc == DUP_LIMIT) begin
            s.threshold = thr_recover;
            s.cwnd      = sat_add(thr_recover, mss3_x);
            s.phase     = PHASE_RECOVER;
            resend      = 1'b1;
          end else if (state_i.phase == PHASE_SLOW && cw_grow >= state_i.threshold) begin
            s.phase = PHASE_AVOID;
          end
        end
        default: begin
          if (dup) begin
            s.cwnd = sat_add(state_i.cwnd, mss_x);
          end else begin
            s.cwnd      = state_i.threshold;
            s.dup_count = 2'd0;
            s.phase     = PHASE_AVOID;
          end
        end
      endcase
      s.prev_ack       = ack;
      s.prev_ack_valid = 1'b1;
    end
  end

  always_comb begin
    win = (s.cwnd < s.adv_window) ? s.cwnd : s.adv_window;
    if (win < mss_w) begin
      win = mss_w;
    end
  end

  assign state_o                       = s;
  assign result_o.send_window          = 32'(win);
  assign result_o.congestion_window    = 32'(s.cwnd);
  assign result_o.slow_start_threshold = 32'(s.threshold);
  assign result_o.phase                = s.phase;
  assign result_o.retransmit           = resend;

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for reno_congestion_window: random and directed ack/timeout words
// depends on rcw_pkg and the reno_congestion_window rtl; predicts every result word itself
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ERROR_PRINTS = 40;
  localparam logic [2:0] SEG_ADDR = {REG_SEGMENT_SIZE, 2'b00};
  localparam logic [2:0] THR_ADDR = {REG_INIT_THRESH, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  in_word_t    in_word = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  out_word_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  in_word_t    event_queue[$];
  out_word_t   predicted_reports[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned sink_stall = 0;
  bit          idling_on = 1'b1;

  // predictor state
  logic [15:0] cfg_mss;
  logic [31:0] cfg_thresh;
  phase_e      cur_phase;
  logic [31:0] win_cwnd;
  logic [31:0] win_ssthresh;
  logic [31:0] win_adv;
  logic [1:0]  dup_run;
  logic [31:0] prev_ack_no;
  logic        ack_seen;

  reno_congestion_window DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [31:0] eff_mss();
    return (cfg_mss == 16'd0) ? 32'd1 : {16'd0, cfg_mss};
  endfunction

  function automatic logic [31:0] window_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void restart_window();
    logic [31:0] th;
    th = (cfg_thresh == 32'd0) ? 32'd1 : cfg_thresh;
    cur_phase    = PHASE_SLOW;
    win_cwnd     = eff_mss();
    win_ssthresh = th;
    win_adv      = th;
    dup_run      = 2'd0;
    prev_ack_no  = '0;
    ack_seen     = 1'b0;
  endfunction

  function automatic out_word_t advance_window(input in_word_t ev);
    logic [31:0] mss;
    logic [31:0] halfw;
    logic [31:0] inc;
    logic [31:0] usable;
    logic [63:0] q;
    logic        dup;
    logic        resend;
    out_word_t   r;
    mss = eff_mss();
    resend = 1'b0;
    if (ev.opcode == OP_TIMEOUT) begin
      halfw = win_cwnd >> 1;
      win_ssthresh = (halfw > mss) ? halfw : mss;
      win_cwnd = mss;
      dup_run = 2'd0;
      cur_phase = PHASE_SLOW;
      resend = 1'b1;
    end else begin
      dup = ack_seen && (ev.ack_number == prev_ack_no);
      win_adv = ev.receiver_window;
      if (cur_phase == PHASE_SLOW || cur_phase == PHASE_AVOID) begin
        if (dup) begin
          if (dup_run != DUP_LIMIT) dup_run++;
        end else begin
          inc = mss;
          if (cur_phase == PHASE_AVOID) begin
            q = (64'(mss) * 64'(mss)) / 64'(win_cwnd);
            if (q > 64'(inc)) inc = q[31:0];
          end
          win_cwnd = window_sum(win_cwnd, inc);
          dup_run = 2'd0;
        end
        if (dup_run == DUP_LIMIT) begin
          halfw = win_cwnd >> 1;
          win_ssthresh = (halfw > mss) ? halfw : mss;
          win_cwnd = window_sum(win_ssthresh, 3 * mss);
          cur_phase = PHASE_RECOVER;
          resend = 1'b1;
        end else if (cur_phase == PHASE_SLOW && win_cwnd >= win_ssthresh) begin
          cur_phase = PHASE_AVOID;
        end
      end else begin
        if (dup) begin
          win_cwnd = window_sum(win_cwnd, mss);
        end else begin
          win_cwnd = win_ssthresh;
          dup_run = 2'd0;
          cur_phase = PHASE_AVOID;
        end
      end
      prev_ack_no = ev.ack_number;
      ack_seen = 1'b1;
    end
    usable = (win_cwnd < win_adv) ? win_cwnd : win_adv;
    if (usable < mss) usable = mss;
    r.send_window          = usable;
    r.congestion_window    = win_cwnd;
    r.slow_start_threshold = win_ssthresh;
    r.phase                = cur_phase;
    r.retransmit           = resend;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] pick_rwin();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'hFFFF_FFFF;
    if (r < 50) return $urandom;
    return $urandom_range(0, 200000);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= ERROR_PRINTS)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) predicted_reports.push_back(advance_window(in_word));
      if (!in_valid || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (event_queue.size() != 0) begin
          in_word <= event_queue.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (predicted_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= ERROR_PRINTS) $error("result word with no prediction waiting");
        end else begin
          want = predicted_reports.pop_front();
          check_field("send_window", want.send_window, out_word_o.send_window);
          check_field("congestion_window", want.congestion_window,
                      out_word_o.congestion_window);
          check_field("slow_start_threshold", want.slow_start_threshold,
                      out_word_o.slow_start_threshold);
          check_field("phase", 32'(want.phase), 32'(out_word_o.phase));
          check_field("retransmit", 32'(want.retransmit), 32'(out_word_o.retransmit));
        end
      end
      if (sink_stall != 0) begin
        out_ready <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid_o && out_ready) sink_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_ack(input logic [31:0] ack, input logic [31:0] rwin);
    in_word_t w;
    w.opcode = OP_ACK;
    w.ack_number = ack;
    w.receiver_window = rwin;
    event_queue.push_back(w);
  endtask

  task automatic push_timeout();
    in_word_t w;
    w.opcode = OP_TIMEOUT;
    w.ack_number = $urandom;
    w.receiver_window = $urandom;
    event_queue.push_back(w);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (event_queue.size() != 0 || in_valid || predicted_reports.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == SEG_ADDR) cfg_mss = data[15:0];
    else cfg_thresh = data;
    restart_window();
    @(negedge clk_i);
  endtask

  // well-formed ack streams with dup bursts and timeouts, plus some noise
  task automatic push_traffic(input int unsigned n, inout logic [31:0] next_ack);
    int unsigned i;
    int unsigned kind;
    int unsigned k;
    i = 0;
    while (i < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        next_ack = next_ack + $urandom_range(1, 3000);
        push_ack(next_ack, pick_rwin());
        i++;
      end else if (kind < 80) begin
        k = $urandom_range(1, 5);
        repeat (k) push_ack(next_ack, pick_rwin());
        i += k;
      end else if (kind < 88) begin
        push_timeout();
        i++;
      end else if (kind < 95) begin
        push_ack($urandom, $urandom);
        i++;
      end else begin
        next_ack = next_ack + $urandom;
        push_ack(next_ack, pick_rwin());
        i++;
      end
    end
  endtask

  initial begin
    logic [31:0] seq;
    cfg_mss = SEGMENT_SIZE_RESET;
    cfg_thresh = INIT_THRESH_RESET;
    restart_window();
    seq = $urandom;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first ack, dups into recovery from slow start, recovery exit, timeouts, extremes
    push_ack(32'd0, 32'd0);
    push_ack(32'd0, 32'hFFFF_FFFF);
    push_ack(32'd0, 32'd3000);
    push_ack(32'd0, 32'd50000);
    push_ack(32'd0, 32'd50000);
    push_ack(32'd0, 32'hFFFF_FFFF);
    push_ack(32'd5000, 32'hFFFF_FFFF);
    push_ack(32'd9000, 32'hFFFF_FFFF);
    repeat (4) push_ack(32'd9000, 32'd7000);
    push_timeout();
    push_timeout();
    push_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_ack(32'hFFFF_FFFF, 32'd1);
    push_ack(32'd0, 32'd1);
    push_ack(32'h5555_5555, 32'hAAAA_AAAA);
    push_ack(32'hAAAA_AAAA, 32'h5555_5555);
    wait_idle();

    // zero segment size and zero threshold
    write_reg(SEG_ADDR, 32'd0);
    write_reg(THR_ADDR, 32'd0);
    push_timeout();
    push_ack(32'd5, 32'd0);
    repeat (3) push_ack(32'd5, 32'd2);
    push_ack(32'd6, 32'd9);
    wait_idle();

    // largest segment and threshold
    write_reg(SEG_ADDR, 32'hFFFF_FFFF);
    write_reg(THR_ADDR, 32'hFFFF_FFFF);
    idling_on = 1'b0;
    for (int unsigned i = 1; i <= 16; i++) push_ack(i, $urandom);
    repeat (3) push_ack(32'd16, 32'hFFFF_FFFF);
    push_ack(32'd70000, 32'hFFFF_FFFF);
    push_timeout();
    wait_idle();
    idling_on = 1'b1;

    write_reg(SEG_ADDR, 32'd1460);
    write_reg(THR_ADDR, 32'd8000);
    push_traffic(120, seq);
    wait_idle();
    push_traffic(130, seq);
    wait_idle();

    write_reg(SEG_ADDR, $urandom_range(1, 300));
    write_reg(THR_ADDR, $urandom_range(1, 5000));
    idling_on = 1'b0;
    push_traffic(100, seq);
    wait_idle();
    idling_on = 1'b1;
    push_traffic(150, seq);
    wait_idle();

    write_reg(THR_ADDR, $urandom);
    write_reg(SEG_ADDR, $urandom_range(1, 65535));
    push_traffic(100, seq);
    wait_idle();
    push_traffic(100, seq);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && predicted_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
